[hdl/mst_pkg.sv]
// Shared package for the modular segment tree sum block.
// Holds field widths, default parameter values and request codes.
// No dependencies.
package mst_pkg;

  // Width of a leaf position field and of a stored or summed value.
  localparam int LW = 11;
  localparam int DW = 30;
  // Bits needed to count through the bits of a value.
  localparam int CW = $clog2(DW);
  // Largest leaf position that a position field can carry.
  localparam int MAX_POS = (1 << LW) - 1;

  localparam int DEF_MAX_LEAVES = 1024;
  localparam int DEF_MODULUS    = 1000000007;

  localparam logic [LW-1:0] CFG_RESET = LW'(1024);

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

endpackage

[hdl/mst_modadd.sv]
// Shared modular adder of the segment tree block: (a + b + cin) mod MODULUS.
// The caller keeps a + b + cin below twice the modulus. Depends on mst_pkg.
module mst_modadd
  import mst_pkg::*;
#(
  parameter int MODULUS = DEF_MODULUS
) (
  input  logic [DW-1:0] a,
  input  logic [DW-1:0] b,
  input  logic          cin,
  output logic [DW-1:0] y
);

  localparam logic [DW:0] MOD_W = (DW+1)'(MODULUS);

  logic [DW:0] sum;
  logic [DW:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b} + {{DW{1'b0}}, cin};
  assign diff = sum - MOD_W;
  // One compare and subtract is enough because the sum stays below 2 * MODULUS.
  assign y    = (sum >= MOD_W) ? diff[DW-1:0] : sum[DW-1:0];

endmodule

[hdl/mst_node_ram.sv]
// Node store of the segment tree block: one write port, one registered read port.
// Addresses beyond the store read as zero and writes there are dropped. Depends on mst_pkg.
module mst_node_ram
  import mst_pkg::*;
#(
  parameter int DEPTH = 2 * DEF_MAX_LEAVES,
  parameter int PW    = $clog2(DEF_MAX_LEAVES) + 2
) (
  input  logic          clk,
  input  logic          we,
  input  logic [PW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [PW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [PW-1:0] LIMIT = PW'(DEPTH);

  logic [DW-1:0] node_mem_r [DEPTH];
  logic [DW-1:0] q_r;
  logic          ok_r;

  always_ff @(posedge clk) begin
    if (we && (waddr < LIMIT)) begin
      node_mem_r[waddr[AW-1:0]] <= wdata;
    end
    q_r  <= node_mem_r[raddr[AW-1:0]];
    ok_r <= (raddr < LIMIT);
  end

  assign rdata = ok_r ? q_r : '0;

endmodule

[hdl/modular_segment_tree_sum.sv]
// Top level of the modular segment tree sum block: sequencer, walk registers, result beat.
// Instantiates mst_node_ram and mst_modadd; depends on mst_pkg.
//
//   channel  | ports                                        | handshake
//   ---------+----------------------------------------------+---------------------------
//   request  | in_req_type in_leaf_index in_add_value       | beat taken when start & !busy
//            | in_range_lo in_range_hi                      |
//   result   | out_range_sum                                | beat is one cycle, out_strobe
//   config   | cfg_wr_data                                  | written when cfg_wr_en
//
// Steps: an add first reduces its value with the shared adder (bit-serial when
// MODULUS < 2**(DW-1)), then descends one level a cycle, updates the leaf and rebuilds
// one level a cycle. A query walks one tree level a cycle, set by the single node store
// read port and the shared modular adder. A clear writes zero to every one of the
// 2*MAX_LEAVES nodes in turn.
// Reset: synchronous, active low. After reset the block sweeps the node store to zero
// with busy high; configuration writes are taken meanwhile.
// The result beat is registered, in the cycle after a query finishes, and cannot be held off.
module modular_segment_tree_sum
  import mst_pkg::*;
#(
  parameter int MAX_LEAVES = DEF_MAX_LEAVES,
  parameter int MODULUS    = DEF_MODULUS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    in_req_type,
  input  logic [LW-1:0] in_leaf_index,
  input  logic [DW-1:0] in_add_value,
  input  logic [LW-1:0] in_range_lo,
  input  logic [LW-1:0] in_range_hi,
  output logic          out_strobe,
  output logic [DW-1:0] out_range_sum,
  input  logic          cfg_wr_en,
  input  logic [LW-1:0] cfg_wr_data
);

  // The store holds 2*MAX_LEAVES nodes. Node numbers can reach almost 4*MAX_LEAVES when
  // the leaf count is not a power of two, so the walk carries one extra bit.
  localparam int NODE_COUNT = 2 * MAX_LEAVES;
  localparam int AW         = $clog2(NODE_COUNT);
  localparam int PW         = $clog2(MAX_LEAVES) + 2;
  localparam int HCAP       = (MAX_LEAVES > MAX_POS) ? MAX_POS : MAX_LEAVES;

  localparam logic [LW-1:0] HCAP_L     = LW'(HCAP);
  localparam logic [LW-1:0] ONE_POS    = LW'(1);
  localparam logic [PW-1:0] ROOT       = PW'(1);
  localparam logic [PW-1:0] NODE_LIMIT = PW'(NODE_COUNT);
  localparam logic [AW-1:0] CLR_LAST   = AW'(NODE_COUNT - 1);
  localparam logic [CW-1:0] CNT_TOP    = CW'(DW - 1);
  localparam logic [DW-1:0] MOD_L      = DW'(MODULUS);
  // A raw add value is below 2**DW; when that is below twice the modulus a single
  // compare and subtract reduces it, otherwise a bit-serial remainder runs.
  localparam bit ONE_STEP = (MODULUS >= (2 ** (DW - 1)));

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_CLEAR  = 10'b00_0000_0010,
    S_RED    = 10'b00_0000_0100,
    S_ADESC  = 10'b00_0000_1000,
    S_ALEAF  = 10'b00_0001_0000,
    S_AUP    = 10'b00_0010_0000,
    S_QSPLIT = 10'b00_0100_0000,
    S_QLEFT  = 10'b00_1000_0000,
    S_QRIGHT = 10'b01_0000_0000,
    S_QDONE  = 10'b10_0000_0000
  } state_t;

  // Control state.
  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic          pend_r, pend_nxt;
  logic          out_strobe_r, out_strobe_nxt;
  logic [LW-1:0] cfg_leaves_r;

  // Walk and payload registers. p/l/r is the current node and its leaf span; p2/l2/r2
  // is where the right-hand walk of a split query starts.
  logic [PW-1:0] p_r, p_nxt, p2_r, p2_nxt;
  logic [LW-1:0] l_r, l_nxt, r_r, r_nxt, l2_r, l2_nxt, r2_r, r2_nxt;
  logic [LW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, idx_r, idx_nxt;
  logic [DW-1:0] val_r, val_nxt, held_r, held_nxt, acc_r, acc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] out_sum_r, out_sum_nxt;

  // Node store ports and shared adder ports.
  logic          ram_we;
  logic [PW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic [DW-1:0] ua, ub, usum;
  logic          ucin;

  // Derived walk values.
  logic [LW-1:0] eff_h, lo_c, hi_c, mid;
  logic [LW:0]   span_sum;
  logic          q_empty;
  logic [PW-1:0] left_c, right_c, parent, sib, parent_sib;

  mst_node_ram #(
    .DEPTH (NODE_COUNT),
    .PW    (PW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mst_modadd #(
    .MODULUS (MODULUS)
  ) u_add (
    .a   (ua),
    .b   (ub),
    .cin (ucin),
    .y   (usum)
  );

  // A leaf count of zero acts as one leaf, and counts above the store are capped.
  assign eff_h = (cfg_leaves_r == '0) ? ONE_POS
               : ((cfg_leaves_r > HCAP_L) ? HCAP_L : cfg_leaves_r);

  // The query range is clipped to the leaves under the root; an empty clipped range
  // answers zero without walking the tree.
  assign lo_c    = (in_range_lo == '0) ? ONE_POS : in_range_lo;
  assign hi_c    = (in_range_hi > eff_h) ? eff_h : in_range_hi;
  assign q_empty = (lo_c > hi_c);

  assign span_sum   = {1'b0, l_r} + {1'b0, r_r};
  assign mid        = span_sum[LW:1];
  assign left_c     = {p_r[PW-2:0], 1'b0};
  assign right_c    = {p_r[PW-2:0], 1'b1};
  assign parent     = {1'b0, p_r[PW-1:1]};
  assign sib        = {p_r[PW-1:1], ~p_r[0]};
  assign parent_sib = {parent[PW-1:1], ~parent[0]};

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    pend_nxt       = 1'b0;
    out_strobe_nxt = 1'b0;
    out_sum_nxt    = out_sum_r;
    p_nxt          = p_r;
    l_nxt          = l_r;
    r_nxt          = r_r;
    p2_nxt         = p2_r;
    l2_nxt         = l2_r;
    r2_nxt         = r2_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    held_nxt       = held_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    ram_we         = 1'b0;
    ram_waddr      = p_r;
    ram_wdata      = usum;
    ram_raddr      = p_r;
    ua             = acc_r;
    ub             = ram_rdata;
    ucin           = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (req_t'(in_req_type))
            REQ_ADD: begin
              idx_nxt   = in_leaf_index;
              val_nxt   = in_add_value;
              held_nxt  = '0;
              cnt_nxt   = CNT_TOP;
              p_nxt     = ROOT;
              l_nxt     = ONE_POS;
              r_nxt     = eff_h;
              state_nxt = S_RED;
            end
            REQ_QUERY: begin
              if (q_empty) begin
                out_strobe_nxt = 1'b1;
                out_sum_nxt    = '0;
              end else begin
                lo_nxt    = lo_c;
                hi_nxt    = hi_c;
                p_nxt     = ROOT;
                l_nxt     = ONE_POS;
                r_nxt     = eff_h;
                acc_nxt   = '0;
                state_nxt = S_QSPLIT;
              end
            end
            REQ_CLEAR: begin
              clr_nxt   = '0;
              state_nxt = S_CLEAR;
            end
            default: begin
              // An unused request code is taken and leaves the state alone.
            end
          endcase
        end
      end

      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = PW'(clr_r);
        ram_wdata = '0;
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end

      S_RED: begin
        if (ONE_STEP) begin
          ua        = val_r;
          ub        = '0;
          val_nxt   = usum;
          state_nxt = S_ADESC;
        end else begin
          // Restoring remainder: shift in one bit of the value a cycle.
          ua       = held_r;
          ub       = held_r;
          ucin     = val_r[cnt_r];
          held_nxt = usum;
          if (cnt_r == '0) begin
            val_nxt   = usum;
            state_nxt = S_ADESC;
          end else begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end
      end

      S_ADESC: begin
        if (l_r == r_r) begin
          // Leaf reached: its read is issued here and lands next cycle.
          state_nxt = S_ALEAF;
        end else if (idx_r <= mid) begin
          p_nxt = left_c;
          r_nxt = mid;
        end else begin
          p_nxt = right_c;
          l_nxt = mid + ONE_POS;
        end
      end

      S_ALEAF: begin
        ua        = ram_rdata;
        ub        = val_r;
        ram_we    = 1'b1;
        ram_waddr = p_r;
        // Hold what a later read of this node would return.
        held_nxt  = (p_r < NODE_LIMIT) ? usum : '0;
        if (p_r == ROOT) begin
          state_nxt = S_IDLE;
        end else begin
          ram_raddr = sib;
          state_nxt = S_AUP;
        end
      end

      S_AUP: begin
        ua        = held_r;
        ub        = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = parent;
        held_nxt  = (parent < NODE_LIMIT) ? usum : '0;
        p_nxt     = parent;
        if (parent == ROOT) begin
          state_nxt = S_IDLE;
        end else begin
          ram_raddr = parent_sib;
        end
      end

      S_QSPLIT: begin
        if ((lo_r <= l_r) && (r_r <= hi_r)) begin
          pend_nxt  = 1'b1;
          state_nxt = S_QDONE;
        end else if (hi_r <= mid) begin
          p_nxt = left_c;
          r_nxt = mid;
        end else if (lo_r > mid) begin
          p_nxt = right_c;
          l_nxt = mid + ONE_POS;
        end else begin
          // The range straddles the midpoint: walk the left edge first, then the right.
          p_nxt     = left_c;
          r_nxt     = mid;
          p2_nxt    = right_c;
          l2_nxt    = mid + ONE_POS;
          r2_nxt    = r_r;
          state_nxt = S_QLEFT;
        end
      end

      S_QLEFT: begin
        if (lo_r <= l_r) begin
          pend_nxt  = 1'b1;
          p_nxt     = p2_r;
          l_nxt     = l2_r;
          r_nxt     = r2_r;
          state_nxt = S_QRIGHT;
        end else if (lo_r > mid) begin
          p_nxt = right_c;
          l_nxt = mid + ONE_POS;
        end else begin
          ram_raddr = right_c;
          pend_nxt  = 1'b1;
          p_nxt     = left_c;
          r_nxt     = mid;
        end
      end

      S_QRIGHT: begin
        if (r_r <= hi_r) begin
          pend_nxt  = 1'b1;
          state_nxt = S_QDONE;
        end else if (hi_r <= mid) begin
          p_nxt = left_c;
          r_nxt = mid;
        end else begin
          ram_raddr = left_c;
          pend_nxt  = 1'b1;
          p_nxt     = right_c;
          l_nxt     = mid + ONE_POS;
        end
      end

      S_QDONE: begin
        out_strobe_nxt = 1'b1;
        out_sum_nxt    = pend_r ? usum : acc_r;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A node read issued last cycle is folded into the running sum now.
    if (pend_r) begin
      acc_nxt = usum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
      cfg_leaves_r <= CFG_RESET;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_wr_en) begin
        cfg_leaves_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r       <= p_nxt;
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    p2_r      <= p2_nxt;
    l2_r      <= l2_nxt;
    r2_r      <= r2_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    idx_r     <= idx_nxt;
    val_r     <= val_nxt;
    held_r    <= held_nxt;
    acc_r     <= acc_nxt;
    cnt_r     <= cnt_nxt;
    out_sum_r <= out_sum_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_strobe    = out_strobe_r;
  assign out_range_sum = out_sum_r;

  // A result beat follows only a finished query or an empty query taken in idle.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (($past(state_r) == S_QDONE) ||
                      $past(start && !busy && (in_req_type == REQ_QUERY))))
    else $error("result beat without a query");

  // Read data waiting to be summed exists only while a query walks the tree.
  assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ((state_r == S_QLEFT) || (state_r == S_QRIGHT) || (state_r == S_QDONE)))
    else $error("pending node read outside a query walk");

  // Every reported sum is fully reduced.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (out_sum_r < MOD_L))
    else $error("result sum not reduced modulo the prime");

endmodule

[tb/modular_segment_tree_sum_tb.sv]
// Self-checking testbench for modular_segment_tree_sum: directed table, then random phases.
// Carries its own segment tree predictor; depends on mst_pkg and the block's RTL only.
`timescale 1ns / 1ps
module modular_segment_tree_sum_tb
  import mst_pkg::*;
();

  // The block runs with its default parameters, so the predictor uses the same ones.
  localparam int              TREE_LEAVES = DEF_MAX_LEAVES;
  localparam int              NODE_SLOTS  = 2 * TREE_LEAVES;
  localparam longint unsigned PRIME       = DEF_MODULUS;
  // Request code that the block must ignore: no result and no change of state.
  localparam logic [1:0]      REQ_IGNORED = 2'd3;
  // A clear walks every node, so this is the longest the block can stay busy
  // on a request that gives no result. Used before a register write.
  localparam int              QUIET_CYCLES = NODE_SLOTS + 16;
  // Cycles left for stray result beats once nothing is expected any more.
  localparam int              DRAIN_CYCLES = 64;
  // Cycles with no beat on either channel before the run is declared hung. The
  // longest legal quiet stretch is the reset sweep or a clear, plus a register
  // pause and a long sender gap, so this is several times over.
  localparam int              STALL_LIMIT  = 20000;

  // One request beat, plus an optional hand-typed expected sum for table rows.
  typedef struct packed {
    logic [1:0]    req;
    logic [LW-1:0] idx;
    logic [DW-1:0] val;
    logic [LW-1:0] lo;
    logic [LW-1:0] hi;
    logic          fixed;
    logic [DW-1:0] fixed_sum;
  } request_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [1:0]    in_req_type = REQ_ADD;
  logic [LW-1:0] in_leaf_index = '0;
  logic [DW-1:0] in_add_value = '0;
  logic [LW-1:0] in_range_lo = '0;
  logic [LW-1:0] in_range_hi = '0;
  logic          out_strobe;
  logic [DW-1:0] out_range_sum;
  logic          cfg_wr_en = 1'b0;
  logic [LW-1:0] cfg_wr_data = '0;

  modular_segment_tree_sum u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_leaf_index (in_leaf_index),
    .in_add_value  (in_add_value),
    .in_range_lo   (in_range_lo),
    .in_range_hi   (in_range_hi),
    .out_strobe    (out_strobe),
    .out_range_sum (out_range_sum),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: the node sums and the leaf count register, kept in step
  // with the block. Both start as the block comes out of reset.
  // ---------------------------------------------------------------------------
  logic [DW-1:0] node_sum [0:NODE_SLOTS-1];
  logic [LW-1:0] leaf_count_reg = CFG_RESET;

  // Sums that queries accepted so far must produce, oldest first.
  logic [DW-1:0] pending_sums [$];
  request_t      table_rows [$];
  int unsigned   mismatches = 0;
  int unsigned   stall_count = 0;

  initial begin
    for (int k = 0; k < NODE_SLOTS; k++) begin
      node_sum[k] = '0;
    end
  end

  function automatic logic [DW-1:0] mod_sum(logic [DW-1:0] a, logic [DW-1:0] b);
    longint unsigned s;
    s = longint'(a) + longint'(b);
    return DW'(s % PRIME);
  endfunction

  // A register value of zero behaves as one leaf, anything above the store as the store.
  function automatic int span_leaves();
    int h;
    h = int'(leaf_count_reg);
    if (h == 0) begin
      h = 1;
    end
    if (h > TREE_LEAVES) begin
      h = TREE_LEAVES;
    end
    return h;
  endfunction

  // Nodes past the end of the store read as zero; writes to them are lost.
  function automatic logic [DW-1:0] node_read(int p);
    return (p < NODE_SLOTS) ? node_sum[p] : '0;
  endfunction

  // Descend to the leaf that owns idx (out-of-range indexes clamp naturally to
  // leaf 1 or leaf h), add the value there, then rebuild every node on the way up.
  function automatic void leaf_add(int idx, logic [DW-1:0] val);
    int p;
    int l;
    int r;
    int m;
    int q;
    int path [$];
    p = 1;
    l = 1;
    r = span_leaves();
    while (l < r) begin
      path.push_back(p);
      m = (l + r) / 2;
      if (idx <= m) begin
        p = 2 * p;
        r = m;
      end else begin
        p = 2 * p + 1;
        l = m + 1;
      end
    end
    if (p < NODE_SLOTS) begin
      node_sum[p] = mod_sum(node_read(p), val);
    end
    while (path.size() != 0) begin
      q = path.pop_back();
      if (q < NODE_SLOTS) begin
        node_sum[q] = mod_sum(node_read(2 * q), node_read(2 * q + 1));
      end
    end
  endfunction

  // Modular sum over [lo, hi] clipped to [1, h], walked with an explicit stack.
  // Addition modulo a prime is order-free, so the walk order does not matter.
  function automatic logic [DW-1:0] range_total(int lo, int hi);
    int sp [$];
    int sl [$];
    int sr [$];
    int p;
    int l;
    int r;
    int m;
    logic [DW-1:0] acc;
    acc = '0;
    if (lo > hi) begin
      return acc;
    end
    sp.push_back(1);
    sl.push_back(1);
    sr.push_back(span_leaves());
    while (sp.size() != 0) begin
      p = sp.pop_back();
      l = sl.pop_back();
      r = sr.pop_back();
      if (l > hi || r < lo) begin
        continue;
      end
      if (lo <= l && r <= hi) begin
        acc = mod_sum(acc, node_read(p));
      end else begin
        m = (l + r) / 2;
        sp.push_back(2 * p);
        sl.push_back(l);
        sr.push_back(m);
        sp.push_back(2 * p + 1);
        sl.push_back(m + 1);
        sr.push_back(r);
      end
    end
    return acc;
  endfunction

  // Apply one accepted beat to the predictor; tells whether a result follows.
  function automatic void apply_request(request_t rq, output bit has_sum,
                                        output logic [DW-1:0] sum);
    has_sum = 1'b0;
    sum = '0;
    case (rq.req)
      REQ_ADD: begin
        // Values above the prime are reduced before they reach the leaf.
        leaf_add(int'(rq.idx), DW'(longint'(rq.val) % PRIME));
      end
      REQ_QUERY: begin
        has_sum = 1'b1;
        sum = range_total(int'(rq.lo), int'(rq.hi));
      end
      REQ_CLEAR: begin
        for (int k = 0; k < NODE_SLOTS; k++) begin
          node_sum[k] = '0;
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
    $display("MISMATCH %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side. The receiver cannot stall, so every strobe is a beat taken at
  // the edge that ends it. Each one is matched against the oldest pending sum.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_sums.size() == 0) begin
        report_mismatch("result beat with no query pending", out_range_sum, '0);
      end else if (out_range_sum !== pending_sums[0]) begin
        report_mismatch("range_sum", out_range_sum, pending_sums.pop_front());
      end else begin
        void'(pending_sums.pop_front());
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_strobe === 1'b1) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
    end
    if (stall_count >= STALL_LIMIT) begin
      $display("modular_segment_tree_sum verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side. start goes high with the fields and stays high until busy is
  // seen low at a rising edge; that edge takes the beat and updates the predictor.
  // ---------------------------------------------------------------------------
  task automatic send_request(request_t rq);
    bit has_sum;
    logic [DW-1:0] sum;
    start         <= 1'b1;
    in_req_type   <= rq.req;
    in_leaf_index <= rq.idx;
    in_add_value  <= rq.val;
    in_range_lo   <= rq.lo;
    in_range_hi   <= rq.hi;
    @(posedge clk);
    while (busy !== 1'b0) begin
      @(posedge clk);
    end
    apply_request(rq, has_sum, sum);
    if (has_sum) begin
      pending_sums.push_back(rq.fixed ? rq.fixed_sum : sum);
    end
  endtask

  // Sender gap: mostly none or short, now and then a long one.
  task automatic sender_gap(bit bursty);
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (bursty || pick < 50) begin
      n = 0;
    end else if (pick < 85) begin
      n = $urandom_range(1, 3);
    end else if (pick < 97) begin
      n = $urandom_range(4, 12);
    end else begin
      n = $urandom_range(20, 60);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Register writes happen only with the block idle: every query answered, and
  // then long enough for a trailing add or clear to have finished as well.
  task automatic write_leaf_count(logic [LW-1:0] value);
    start <= 1'b0;
    while (pending_sums.size() != 0) begin
      @(posedge clk);
    end
    repeat (QUIET_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    leaf_count_reg = value;
    cfg_wr_en <= 1'b0;
  endtask

  function automatic request_t row(logic [1:0] req, int idx, logic [DW-1:0] val,
                                   int lo, int hi, bit fixed, logic [DW-1:0] fixed_sum);
    request_t rq;
    rq.req       = req;
    rq.idx       = LW'(idx);
    rq.val       = val;
    rq.lo        = LW'(lo);
    rq.hi        = LW'(hi);
    rq.fixed     = fixed;
    rq.fixed_sum = fixed_sum;
    return rq;
  endfunction

  // Random beat for a tree of h leaves. Every field gets random bits first so
  // that all bits toggle, then the operation shapes the fields it uses.
  function automatic request_t random_request(int h, bit allow_ignored);
    request_t rq;
    int pick;
    int a;
    int b;
    rq.idx       = LW'($urandom);
    rq.val       = DW'($urandom);
    rq.lo        = LW'($urandom);
    rq.hi        = LW'($urandom);
    rq.fixed     = 1'b0;
    rq.fixed_sum = '0;
    pick = $urandom_range(0, 99);
    if (allow_ignored && pick >= 93 && pick < 97) begin
      rq.req = REQ_IGNORED;
    end else if (pick >= 97) begin
      rq.req = REQ_CLEAR;
    end else if (pick < 45) begin
      rq.req = REQ_ADD;
      if ($urandom_range(0, 9) != 0) begin
        rq.idx = LW'($urandom_range(1, h));
      end
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        rq.val = DW'($urandom_range(0, int'(PRIME) - 1));
      end else if (pick < 17) begin
        rq.val = (pick == 14) ? '0 : DW'(PRIME - 1);
      end
      // Otherwise the raw 30-bit value stays, often above the prime.
    end else begin
      rq.req = REQ_QUERY;
      pick = $urandom_range(0, 19);
      a = $urandom_range(1, h);
      b = $urandom_range(1, h);
      if (pick < 15) begin
        rq.lo = LW'((a < b) ? a : b);
        rq.hi = LW'((a < b) ? b : a);
      end else if (pick < 17 && a != b) begin
        rq.lo = LW'((a < b) ? b : a);
        rq.hi = LW'((a < b) ? a : b);
      end
    end
    return rq;
  endfunction

  // Leaf counts visited by the random phases. They include zero (acts as one
  // leaf), all ones (clamps to the full store), odd and non-power-of-two shapes.
  // There is no clear between phases, so each new shape walks the old contents.
  int leaf_plan [] = '{1024, 1, 0, 2047, 1000, 2, 3, 777, 512, 1024};

  initial begin
    request_t rq;
    int h;
    int sent;
    int per_phase;
    bit bursty;

    // Directed table. Typed sums are those that are obvious: an empty tree,
    // an empty range, or a range that misses every leaf.
    table_rows.push_back(row(REQ_QUERY, 0, '0, 1, 1024, 1'b1, '0));
    table_rows.push_back(row(REQ_QUERY, 0, '0, 5, 4, 1'b1, '0));
    table_rows.push_back(row(REQ_QUERY, 0, '0, 0, 0, 1'b1, '0));
    table_rows.push_back(row(REQ_ADD, 1, DW'(PRIME - 1), 0, 0, 1'b0, '0));
    table_rows.push_back(row(REQ_ADD, 1024, DW'(5), 0, 0, 1'b0, '0));
    table_rows.push_back(row(REQ_QUERY, 0, '0, 1, 1024, 1'b0, '0));
    // Index zero lands on the first leaf, an index past the end on the last.
    table_rows.push_back(row(REQ_ADD, 0, DW'(3), 0, 0, 1'b0, '0));
    table_rows.push_back(row(REQ_ADD, MAX_POS, DW'(7), 0, 0, 1'b0, '0));
    // All-ones value lies above the prime and is reduced before it reaches the leaf.
    table_rows.push_back(row(REQ_ADD, 512, '1, 0, 0, 1'b0, '0));
    table_rows.push_back(row(REQ_QUERY, 0, '0, 0, MAX_POS, 1'b0, '0));
    table_rows.push_back(row(REQ_QUERY, 0, '0, 512, 512, 1'b0, '0));
    table_rows.push_back(row(REQ_QUERY, 0, '0, 1, 1, 1'b0, '0));
    table_rows.push_back(row(REQ_IGNORED, MAX_POS, '1, MAX_POS, 0, 1'b0, '0));
    table_rows.push_back(row(REQ_QUERY, 0, '0, 1024, 1024, 1'b0, '0));
    table_rows.push_back(row(REQ_QUERY, 0, '0, 1025, MAX_POS, 1'b1, '0));
    table_rows.push_back(row(REQ_QUERY, 0, '0, 513, 1023, 1'b0, '0));
    table_rows.push_back(row(REQ_CLEAR, 0, '0, 0, 0, 1'b0, '0));
    table_rows.push_back(row(REQ_QUERY, 0, '0, 1, 1024, 1'b1, '0));
    table_rows.push_back(row(REQ_ADD, 700, '0, 0, 0, 1'b0, '0));
    table_rows.push_back(row(REQ_QUERY, 0, '0, 700, 700, 1'b1, '0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // The first row doubles as a check of the reset leaf count and the
    // cleared store; busy covers the clearing sweep that follows reset.
    foreach (table_rows[i]) begin
      send_request(table_rows[i]);
      sender_gap(1'b0);
    end

    per_phase = 55;
    foreach (leaf_plan[ph]) begin
      write_leaf_count(LW'(leaf_plan[ph]));
      h = span_leaves();
      bursty = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < per_phase) begin
        rq = random_request(h, 1'b1);
        send_request(rq);
        if (rq.req != REQ_IGNORED) begin
          sent++;
        end
        sender_gap(bursty);
      end
    end

    start <= 1'b0;
    while (pending_sums.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("modular_segment_tree_sum verification clean");
    end else begin
      $display("modular_segment_tree_sum verification failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/mst_pkg.sv
hdl/mst_modadd.sv
hdl/mst_node_ram.sv
hdl/modular_segment_tree_sum.sv
tb/modular_segment_tree_sum_tb.sv
